FILE: hdl/hrp_pkg.sv
`timescale 1ns / 1ps

package hrp_pkg;

    localparam int SERVER_LIMIT = 1024;
    localparam int DRAIN_CYCLES = 10;

    typedef enum logic [1:0] {
        REG_SERVER_COUNT   = 2'd0,
        REG_VIRTUAL_FACTOR = 2'd1,
        REG_HASH_SEED      = 2'd2
    } reg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [63:0] object_key;
        logic [3:0]  replica_count;
    } in_item_t;

    typedef struct packed {
        logic [9:0] server_index;
        logic [2:0] replica_rank;
        logic       found;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic       found;
        logic [9:0] server_index;
    } slot_t;

endpackage

FILE: hdl/hrp_hash.sv
`timescale 1ns / 1ps

module hrp_hash
    import hrp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [63:0] key,
    input  logic [31:0] pc,
    input  logic [31:0] pb,
    input  logic [9:0]  in_tag,
    output logic        out_valid,
    output logic [63:0] result,
    output logic [9:0]  out_tag
);

    function automatic logic [31:0] rotl(input logic [31:0] x, input int k);
        rotl = (x << k) | (x >> (32 - k));
    endfunction

    logic [3:0]  valid_reg;
    logic [31:0] a_reg [3];
    logic [31:0] b_reg [4];
    logic [31:0] c_reg [4];
    logic [9:0]  tag_reg [4];

    logic [31:0] a0, b0, c0, a1, b1, c1, a2, b2, c2, b3, c3, c4;

    always_comb
    begin
        a0 = 32'hdeadbeef + 32'd8 + pc;
        b0 = a0 + key[63:32];
        c0 = a0 + pb;
        a0 = a0 + key[31:0];
        c0 = (c0 ^ b0) - rotl(b0, 14);
        a0 = (a0 ^ c0) - rotl(c0, 11);
        a1 = a_reg[0];
        b1 = (b_reg[0] ^ a_reg[0]) - rotl(a_reg[0], 25);
        c1 = (c_reg[0] ^ b1) - rotl(b1, 16);
        b2 = b_reg[1];
        c2 = c_reg[1];
        a2 = (a_reg[1] ^ c_reg[1]) - rotl(c_reg[1], 4);
        b2 = (b2 ^ a2) - rotl(a2, 14);
        b3 = b_reg[2];
        c3 = c_reg[2];
        c4 = (c3 ^ b3) - rotl(b3, 24);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg[0]   <= a0;
        b_reg[0]   <= b0;
        c_reg[0]   <= c0;
        tag_reg[0] <= in_tag;
        a_reg[1]   <= a1;
        b_reg[1]   <= b1;
        c_reg[1]   <= c1;
        tag_reg[1] <= tag_reg[0];
        a_reg[2]   <= a2;
        b_reg[2]   <= b2;
        c_reg[2]   <= c2;
        tag_reg[2] <= tag_reg[1];
        b_reg[3]   <= b3;
        c_reg[3]   <= c4;
        tag_reg[3] <= tag_reg[2];
    end

    assign out_valid = valid_reg[3];
    assign result    = {b_reg[3], c_reg[3]};
    assign out_tag   = tag_reg[3];

endmodule

FILE: hdl/hrp_rank.sv
`timescale 1ns / 1ps

module hrp_rank
    import hrp_pkg::*;
#(
    parameter int MAX_REPLICAS = 8,
    parameter int RW = 4,
    parameter int SW = 3
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          clear,
    input  logic [RW-1:0] reps,
    input  logic          in_valid,
    input  logic [63:0]   in_dist,
    input  logic [9:0]    in_idx,
    input  logic [SW-1:0] rd_slot,
    output slot_t         rd_data
);

    logic [MAX_REPLICAS-1:0] valid_reg;
    logic [MAX_REPLICAS-1:0] valid_next;
    logic [MAX_REPLICAS-1:0] take;
    logic [9:0]  idx_reg   [MAX_REPLICAS];
    logic [63:0] dist_reg  [MAX_REPLICAS];
    logic [9:0]  idx_next  [MAX_REPLICAS];
    logic [63:0] dist_next [MAX_REPLICAS];

    always_comb
    begin
        for (int r = 0; r < MAX_REPLICAS; r++)
        begin
            take[r] = (RW'(r) < reps) && (!valid_reg[r] || (in_dist < dist_reg[r]));
        end
        for (int r = 0; r < MAX_REPLICAS; r++)
        begin
            valid_next[r] = valid_reg[r];
            idx_next[r]   = idx_reg[r];
            dist_next[r]  = dist_reg[r];
            if (take[r])
            begin
                if (r > 0 && take[(r > 0) ? r - 1 : 0])
                begin
                    valid_next[r] = valid_reg[(r > 0) ? r - 1 : 0];
                    idx_next[r]   = idx_reg[(r > 0) ? r - 1 : 0];
                    dist_next[r]  = dist_reg[(r > 0) ? r - 1 : 0];
                end
                else
                begin
                    valid_next[r] = 1'b1;
                    idx_next[r]   = in_idx;
                    dist_next[r]  = in_dist;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (clear)
        begin
            valid_reg <= '0;
        end
        else if (in_valid)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !clear)
        begin
            for (int r = 0; r < MAX_REPLICAS; r++)
            begin
                idx_reg[r]  <= idx_next[r];
                dist_reg[r] <= dist_next[r];
            end
        end
    end

    assign rd_data.found        = valid_reg[rd_slot];
    assign rd_data.server_index = valid_reg[rd_slot] ? idx_reg[rd_slot] : 10'd0;

endmodule

FILE: hdl/hash_replica_placement.sv
`timescale 1ns / 1ps

// Replica placement by nearest virtual node.
// Configuration is written through cfg_valid/cfg_index/cfg_data, and cfg_ready
// is always high. The user must write only while the block is idle; the block
// does not enforce this. Index 0 is server count, 1 virtual factor, 2 hash seed.
// An input item carries a 64-bit object key and a replica count. It is accepted
// when in_valid is high and in_stall is low; in_stall is high while a query is
// in progress, so one query is handled at a time.
// Each virtual node enters the hash pipeline in its own cycle. A query runs its
// N nodes, N being the node count (server count times virtual factor, at most
// MAX_VNODES), through the node hash and the distance hash, drains their nine
// pipeline stages and then emits R results, R being the replica count.
// Results leave one per cycle while out_stall is low, through a registered
// output, nearest first, with last set on the final one. When out_stall is high
// the output item holds and the block waits; nothing is lost or repeated. A
// replica count of zero gives no results. After reset the registers hold server
// count 1, virtual factor 1 and seed 0, and the block is idle.

module hash_replica_placement
    import hrp_pkg::*;
#(
    parameter int MAX_VNODES = 1024,
    parameter int MAX_REPLICAS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int CW = $clog2(MAX_VNODES + 1);
    localparam int RW = $clog2(MAX_REPLICAS + 1);
    localparam int SW = (MAX_REPLICAS > 1) ? $clog2(MAX_REPLICAS) : 1;

    logic [10:0] server_count_reg;
    logic [10:0] virtual_factor_reg;
    logic [31:0] hash_seed_reg;

    state_t      state_reg, state_next;
    logic [63:0] key_reg, key_next;
    logic [RW-1:0] reps_reg, reps_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] n_reg, n_next;
    logic [10:0] s_reg, s_next;
    logic [9:0]  srv_reg, srv_next;
    logic [9:0]  num_reg, num_next;
    logic [3:0]  drain_reg, drain_next;
    logic [RW-1:0] emit_reg, emit_next;
    logic        out_valid_reg, out_valid_next;
    out_item_t   out_data_reg, out_data_next;

    logic [10:0] s_sat, f_sat;
    logic [21:0] prod;
    logic [RW-1:0] reps_sat;
    logic        accept, issue, start;

    logic        h1_valid;
    logic [63:0] h1_id;
    logic [9:0]  h1_tag;
    logic        prep_valid_reg;
    logic [63:0] prep_lo_reg, prep_hi_reg;
    logic [9:0]  prep_tag_reg;
    logic        h2_valid;
    logic [63:0] h2_dist;
    logic [9:0]  h2_tag;
    slot_t       rd_data;

    assign cfg_ready = 1'b1;
    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign issue     = (state_reg == ST_RUN);
    assign start     = accept;

    assign s_sat = (server_count_reg > 11'(SERVER_LIMIT)) ? 11'(SERVER_LIMIT) : server_count_reg;
    assign f_sat = (virtual_factor_reg > 11'(SERVER_LIMIT)) ? 11'(SERVER_LIMIT)
                                                             : virtual_factor_reg;
    assign prod  = s_sat * f_sat;
    assign reps_sat = (32'(in_data.replica_count) > 32'(MAX_REPLICAS))
                      ? RW'(MAX_REPLICAS) : RW'(in_data.replica_count);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            server_count_reg   <= 11'd1;
            virtual_factor_reg <= 11'd1;
            hash_seed_reg      <= 32'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SERVER_COUNT:   server_count_reg   <= cfg_data[10:0];
                REG_VIRTUAL_FACTOR: virtual_factor_reg <= cfg_data[10:0];
                REG_HASH_SEED:      hash_seed_reg      <= cfg_data;
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        key_next       = key_reg;
        reps_next      = reps_reg;
        count_next     = count_reg;
        n_next         = n_reg;
        s_next         = s_reg;
        srv_next       = srv_reg;
        num_next       = num_reg;
        drain_next     = drain_reg;
        emit_next      = emit_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    key_next   = in_data.object_key;
                    reps_next  = reps_sat;
                    s_next     = s_sat;
                    count_next = ({10'd0, prod} > 32'(MAX_VNODES)) ? CW'(MAX_VNODES)
                                                                    : CW'(prod);
                    n_next     = '0;
                    srv_next   = '0;
                    num_next   = '0;
                    drain_next = '0;
                    emit_next  = '0;
                    state_next = (prod == 22'd0) ? ST_DRAIN : ST_RUN;
                end
            end
            ST_RUN:
            begin
                n_next = CW'(n_reg + 1'b1);
                if ({1'b0, srv_reg} + 11'd1 == s_reg)
                begin
                    srv_next = '0;
                    num_next = num_reg + 10'd1;
                end
                else
                begin
                    srv_next = srv_reg + 10'd1;
                end
                if (CW'(n_reg + 1'b1) == count_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                drain_next = drain_reg + 4'd1;
                if (drain_reg == 4'(DRAIN_CYCLES - 1))
                begin
                    state_next = (reps_reg == '0) ? ST_IDLE : ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next             = 1'b1;
                    out_data_next.server_index = rd_data.server_index;
                    out_data_next.replica_rank = 3'(emit_reg);
                    out_data_next.found        = rd_data.found;
                    out_data_next.last         = (RW'(emit_reg + 1'b1) == reps_reg);
                    emit_next                  = RW'(emit_reg + 1'b1);
                    if (RW'(emit_reg + 1'b1) == reps_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            n_reg         <= '0;
            srv_reg       <= '0;
            num_reg       <= '0;
            drain_reg     <= '0;
            emit_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            srv_reg       <= srv_next;
            num_reg       <= num_next;
            drain_reg     <= drain_next;
            emit_reg      <= emit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        reps_reg     <= reps_next;
        count_reg    <= count_next;
        s_reg        <= s_next;
        out_data_reg <= out_data_next;
    end

    hrp_hash u_node_hash (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (issue),
        .key       ({54'd0, srv_reg}),
        .pc        ({22'd0, num_reg}),
        .pb        (hash_seed_reg),
        .in_tag    (srv_reg),
        .out_valid (h1_valid),
        .result    (h1_id),
        .out_tag   (h1_tag)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_valid_reg <= 1'b0;
        end
        else
        begin
            prep_valid_reg <= h1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        prep_hi_reg  <= (key_reg > h1_id) ? key_reg : h1_id;
        prep_lo_reg  <= (key_reg > h1_id) ? h1_id : key_reg;
        prep_tag_reg <= h1_tag;
    end

    hrp_hash u_dist_hash (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prep_valid_reg),
        .key       (prep_lo_reg),
        .pc        (prep_hi_reg[31:0]),
        .pb        (prep_hi_reg[63:32]),
        .in_tag    (prep_tag_reg),
        .out_valid (h2_valid),
        .result    (h2_dist),
        .out_tag   (h2_tag)
    );

    hrp_rank #(
        .MAX_REPLICAS (MAX_REPLICAS),
        .RW           (RW),
        .SW           (SW)
    ) u_rank (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (start),
        .reps     (reps_reg),
        .in_valid (h2_valid),
        .in_dist  (h2_dist),
        .in_idx   (h2_tag),
        .rd_slot  (SW'(emit_reg)),
        .rd_data  (rd_data)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.found |-> out_data.server_index == 10'd0)
        else $error("result without a node carries a nonzero server index");

    a_emit_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> !h2_valid && !prep_valid_reg && !h1_valid)
        else $error("results emitted while nodes are still in the pipeline");

    a_emit_continues: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !out_data.last && state_reg == ST_EMIT |=> out_valid)
        else $error("gap between results of one query");

endmodule
